@@ sv/assert_macros.svh @@
// Assertion macros for the RTL; double_ended_queue.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

@@ sv/dq_pkg.sv @@
package dq_pkg;

  localparam int DATA_W        = 32;
  localparam int DEFAULT_DEPTH = 16;
  localparam int ACTION_W      = 3;
  localparam int STATUS_W      = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_REAR  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_REAR   = 3'd3,
    ACT_LIST       = 3'd4
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LIST
  } state_t;

endpackage

@@ sv/double_ended_queue.sv @@
// Bounded double-ended queue of signed 32-bit values held in a ring of DEPTH entries.
// The request channel (s_*) carries the action in s_tuser and the value in s_tdata.
// Actions are push front, push rear, pop front, pop rear and list contents; codes
// five to seven are dropped without a result. The result channel (m_*) carries the
// status in m_tuser, the element in m_tdata and marks the final result with m_tlast.
// One request is handled at a time: when it is taken the entry RAM read is issued,
// and the registered read data is used in the execute state. A list streams one
// element per cycle through the single RAM read port while the receiver does not
// stall. The first result is loaded into the output register from the execute
// state, once that register is free. A request is taken while the previous result
// still sits in the output register; if the receiver stalls, the block holds its
// result and waits, and takes no further request until that result has moved on.
// Reset empties the queue and sets the front index to zero; the entry RAM is not
// cleared, since only occupied entries are ever returned as results.
`include "assert_macros.svh"

module double_ended_queue
  import dq_pkg::*;
#(
  parameter int DEPTH = DEFAULT_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [DATA_W-1:0]   s_tdata,   // value
  input  logic [ACTION_W-1:0] s_tuser,   // action
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [DATA_W-1:0]   m_tdata,   // element
  output logic [STATUS_W-1:0] m_tuser,   // status
  output logic                m_tlast
);

  localparam int IW = $clog2(DEPTH);
  localparam int OW = $clog2(DEPTH + 1);

  state_t            state, state_next;
  logic [IW-1:0]     front, front_next;
  logic [OW-1:0]     occ, occ_next;
  logic [IW-1:0]     list_pos, list_pos_next;
  action_t           req_action;
  logic [DATA_W-1:0] req_value;

  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_data;

  logic              out_free;
  logic              out_load;
  status_t           out_status;
  logic [DATA_W-1:0] out_elem;
  logic              out_last;

  function automatic logic [IW-1:0] slot(input logic [IW-1:0] base,
                                         input logic [IW-1:0] offset);
    logic [IW:0] sum;
    sum = {1'b0, base} + {1'b0, offset};
    if (sum >= (IW+1)'(DEPTH)) begin
      sum = sum - (IW+1)'(DEPTH);
    end
    return sum[IW-1:0];
  endfunction

  dq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (req_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      front    <= '0;
      occ      <= '0;
      list_pos <= '0;
    end else begin
      state    <= state_next;
      front    <= front_next;
      occ      <= occ_next;
      list_pos <= list_pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_action <= action_t'(s_tuser);
      req_value  <= s_tdata;
    end
  end

  always_comb begin
    state_next    = state;
    front_next    = front;
    occ_next      = occ;
    list_pos_next = list_pos;
    wr_en         = 1'b0;
    wr_addr       = front;
    rd_en         = 1'b0;
    rd_addr       = front;
    out_load      = 1'b0;
    out_status    = ST_OK;
    out_elem      = '0;
    out_last      = 1'b1;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          rd_en = 1'b1;
          if (action_t'(s_tuser) == ACT_POP_REAR) begin
            rd_addr = slot(front, IW'(occ - 1'b1));
          end
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_next = S_IDLE;
          case (req_action)
            ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
              out_load = 1'b1;
              if (occ == OW'(DEPTH)) begin
                out_status = ST_FULL;
              end else begin
                wr_en    = 1'b1;
                occ_next = occ + 1'b1;
                if (req_action == ACT_PUSH_FRONT) begin
                  wr_addr    = (front == '0) ? IW'(DEPTH - 1) : front - 1'b1;
                  front_next = wr_addr;
                end else begin
                  wr_addr = slot(front, IW'(occ));
                end
              end
            end
            ACT_POP_FRONT, ACT_POP_REAR: begin
              out_load = 1'b1;
              if (occ == '0) begin
                out_status = ST_EMPTY;
              end else begin
                out_elem = rd_data;
                occ_next = occ - 1'b1;
                if (req_action == ACT_POP_FRONT) begin
                  front_next = (front == IW'(DEPTH - 1)) ? '0 : front + 1'b1;
                end
              end
            end
            ACT_LIST: begin
              out_load = 1'b1;
              if (occ == '0) begin
                out_status = ST_EMPTY;
              end else begin
                out_elem = rd_data;
                out_last = (occ == OW'(1));
                if (!out_last) begin
                  rd_en         = 1'b1;
                  rd_addr       = slot(front, IW'(1));
                  list_pos_next = IW'(1);
                  state_next    = S_LIST;
                end
              end
            end
            default: begin
              out_load = 1'b0;
            end
          endcase
        end
      end
      S_LIST: begin
        if (out_free) begin
          out_load = 1'b1;
          out_elem = rd_data;
          out_last = (OW'(list_pos) + 1'b1 == occ);
          if (out_last) begin
            state_next = S_IDLE;
          end else begin
            rd_en         = 1'b1;
            rd_addr       = slot(front, list_pos + 1'b1);
            list_pos_next = list_pos + 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= out_elem;
      m_tuser <= out_status;
      m_tlast <= out_last;
    end
  end

  `ASSERT_NEVER(a_occ_bound, clk, rst, occ > OW'(DEPTH), "occupancy exceeds depth")
  `ASSERT_CLK(a_write_room, clk, rst, wr_en |-> occ < OW'(DEPTH), "write into full queue")
  `ASSERT_CLK(a_accept_exec, clk, rst, (s_tvalid && s_tready) |=> state == S_EXEC,
    "request taken without execution")
  `ASSERT_CLK(a_list_range, clk, rst, state == S_LIST |-> OW'(list_pos) < occ,
    "list position beyond occupancy")
  `ASSERT_CLK(a_load_free, clk, rst, out_load |-> out_free, "result overwrites pending result")

endmodule

@@ sv/dq_ram.sv @@
module dq_ram
  import dq_pkg::*;
#(
  parameter int WIDTH = DATA_W,
  parameter int DEPTH = DEFAULT_DEPTH,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ tb/double_ended_queue_tb.sv @@
module double_ended_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dq_pkg::*;

  localparam int DEPTH       = DEFAULT_DEPTH;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    status_t            status;
    logic [DATA_W-1:0]  element;
    logic               last;
  } result_t;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [DATA_W-1:0]   s_tdata  = '0;
  logic [ACTION_W-1:0] s_tuser  = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [DATA_W-1:0]   m_tdata;
  logic [STATUS_W-1:0] m_tuser;
  logic                m_tlast;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors        = 0;
  int cycles        = 0;

  result_t           owed_results[$];
  logic [DATA_W-1:0] ring[DEPTH];
  int unsigned       head  = 0;
  int unsigned       count = 0;

  double_ended_queue #(.DEPTH(DEPTH)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("double_ended_queue_tb: errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic void owe(status_t status, logic [DATA_W-1:0] element, logic last);
    result_t r;
    r.status  = status;
    r.element = element;
    r.last    = last;
    owed_results.push_back(r);
  endfunction

  // Applies one accepted item to the ring and queues the results it causes.
  function automatic void deque_apply(logic [ACTION_W-1:0] act, logic [DATA_W-1:0] val);
    int unsigned k;
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
        if (count >= DEPTH) begin
          owe(ST_FULL, '0, 1'b1);
        end else begin
          if (act == ACT_PUSH_FRONT) begin
            head = (head + DEPTH - 1) % DEPTH;
            ring[head] = val;
          end else begin
            ring[(head + count) % DEPTH] = val;
          end
          count++;
          owe(ST_OK, '0, 1'b1);
        end
      end
      ACT_POP_FRONT, ACT_POP_REAR: begin
        if (count == 0) begin
          owe(ST_EMPTY, '0, 1'b1);
        end else begin
          if (act == ACT_POP_FRONT) begin
            owe(ST_OK, ring[head], 1'b1);
            head = (head + 1) % DEPTH;
          end else begin
            owe(ST_OK, ring[(head + count - 1) % DEPTH], 1'b1);
          end
          count--;
        end
      end
      ACT_LIST: begin
        if (count == 0) begin
          owe(ST_EMPTY, '0, 1'b1);
        end else begin
          for (k = 0; k < count; k++) begin
            owe(ST_OK, ring[(head + k) % DEPTH], (k + 1 == count));
          end
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected item status=%0d element=%0d last=%0b", $time, m_tuser,
                 $signed(m_tdata), m_tlast);
        errors++;
      end else begin
        want = owed_results.pop_front();
        if (m_tuser !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, m_tuser);
          errors++;
        end
        if (m_tdata !== want.element) begin
          $display("%0t: element expected %0d actual %0d", $time, $signed(want.element),
                   $signed(m_tdata));
          errors++;
        end
        if (m_tlast !== want.last) begin
          $display("%0t: last expected %0b actual %0b", $time, want.last, m_tlast);
          errors++;
        end
      end
    end
  end

  task automatic send_request(input logic [ACTION_W-1:0] act, input logic [DATA_W-1:0] val);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= val;
    do @(posedge clk); while (!s_tready);
    deque_apply(act, val);
  endtask

  task automatic hold_off();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (owed_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic [DATA_W-1:0] rand_value();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_empty_queue();
    send_request(ACT_POP_FRONT, 32'h1234_5678);
    send_request(ACT_POP_REAR, '1);
    send_request(ACT_LIST, '0);
  endtask

  task automatic test_extreme_values();
    send_request(ACT_PUSH_REAR, 32'h8000_0000);
    send_request(ACT_PUSH_FRONT, 32'h7fff_ffff);
    send_request(ACT_PUSH_REAR, 32'hffff_ffff);
    send_request(ACT_PUSH_FRONT, 32'h0000_0000);
    send_request(ACT_LIST, 32'h5555_5555);
    send_request(ACT_POP_FRONT, 32'haaaa_aaaa);
    send_request(ACT_POP_REAR, '0);
  endtask

  task automatic test_undefined_codes();
    send_request(3'd5, 32'hdead_beef);
    send_request(3'd6, '1);
    send_request(3'd7, 32'h0bad_f00d);
    send_request(ACT_LIST, '0);
  endtask

  task automatic test_fill_and_overflow();
    while (count < DEPTH) begin
      send_request($urandom_range(1) ? ACT_PUSH_FRONT : ACT_PUSH_REAR, rand_value());
    end
    send_request(ACT_PUSH_FRONT, $urandom);
    send_request(ACT_PUSH_REAR, $urandom);
    send_request(ACT_LIST, '0);
    while (count > 0) begin
      send_request($urandom_range(1) ? ACT_POP_FRONT : ACT_POP_REAR, $urandom);
    end
  endtask

  task automatic test_random_traffic(input int n);
    int                  sent;
    int                  push_bias;
    int                  roll;
    logic [ACTION_W-1:0] act;
    sent      = 0;
    push_bias = 50;
    while (sent < n) begin
      if (sent % 12 == 0) push_bias = $urandom_range(20, 80);
      roll = $urandom_range(99);
      if (roll < 4) begin
        act = 3'($urandom_range(5, 7));
      end else if (roll < 14) begin
        act = ACT_LIST;
      end else if ($urandom_range(99) < push_bias) begin
        act = $urandom_range(1) ? ACT_PUSH_FRONT : ACT_PUSH_REAR;
      end else begin
        act = $urandom_range(1) ? ACT_POP_FRONT : ACT_POP_REAR;
      end
      send_request(act, rand_value());
      if (act <= ACT_LIST) sent++;
    end
  endtask

  initial begin
    send_idle_pct = 7;
    recv_idle_pct = 45;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_queue();
    test_extreme_values();
    test_undefined_codes();
    test_fill_and_overflow();
    test_random_traffic(40);
    hold_off();

    send_idle_pct = 45;
    recv_idle_pct = 7;
    test_random_traffic(40);
    hold_off();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(40);
    hold_off();
    repeat (20) @(negedge clk);

    if (errors == 0 && owed_results.size() == 0) begin
      $display("double_ended_queue_tb: clean");
    end else begin
      $display("double_ended_queue_tb: errors");
    end
    $finish;
  end

endmodule
